/* hdl/tdtr_pkg.sv */
// shared types and constants of the triangle depth test rasteriser
package tdtr_pkg;

  // default sizes of the depth store
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int DEPTH_BITS_DEF = 24;

  // configuration register width and reset values
  localparam int CFG_BITS = 10;
  localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RST  = 10'd512;
  localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RST = 10'd512;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // width of the shared divider
  localparam int DIV_BITS = 64;

  // input word: triangle, candidate pixel and colour
  typedef struct packed {
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [23:0] v0_z;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [23:0] v1_z;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic signed [23:0] v2_z;
    logic [8:0]         pixel_x;
    logic [8:0]         pixel_y;
    logic [31:0]        pixel_color;
  } in_word_t;

  // output word: pixel write
  typedef struct packed {
    logic               write_enable;
    logic [8:0]         out_x;
    logic [8:0]         out_y;
    logic [31:0]        out_color;
    logic signed [23:0] out_depth;
  } out_word_t;

endpackage

/* hdl/triangle_depth_test_raster_unit.sv */
// triangle pixel coverage, depth interpolation and depth test: top level
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | in_word (tdtr_pkg::in_word_t)
//  out     | output    | out_valid / out_stall | out_word (tdtr_pkg::out_word_t)
//  cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// one word in flight: a covered pixel passes the weight products, the orient step,
// the depth products, the divider start, the wait on the iterative divider, the
// store read and the compare; a rejected pixel goes from the orient step to output.
// after reset all MAX_WIDTH*MAX_HEIGHT store entries are swept to farthest,
// during which in_stall is high.
// a finished word waits in the output register while the next is taken.
module triangle_depth_test_raster_unit #(
  parameter int MAX_WIDTH  = tdtr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tdtr_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = tdtr_pkg::DEPTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tdtr_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tdtr_pkg::out_word_t             out_word,
  input  logic                            cfg_write,
  input  tdtr_pkg::cfg_reg_t              cfg_index,
  input  logic [tdtr_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int DB    = tdtr_pkg::DIV_BITS;
  localparam logic signed [64:0] ZMAX = 65'((65'sd1 <<< (DEPTH_BITS - 1)) - 65'sd1);
  localparam logic signed [64:0] ZMIN = -ZMAX - 65'sd1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_WMUL = 9'b000000010,
    ST_NORM = 9'b000000100,
    ST_NMUL = 9'b000001000,
    ST_DIVS = 9'b000010000,
    ST_DIVW = 9'b000100000,
    ST_RD   = 9'b001000000,
    ST_CMP  = 9'b010000000,
    ST_REJ  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [tdtr_pkg::CFG_BITS-1:0] image_width;
  logic [tdtr_pkg::CFG_BITS-1:0] image_height;
  logic [WB-1:0] wl;
  logic [HB-1:0] hl;

  tdtr_pkg::in_word_t item;
  logic signed [16:0] e1x, e1y, e2x, e2y;
  logic signed [17:0] dx, dy;
  logic [AW-1:0]      idx;
  logic               inimg;
  logic [2:0]         k;

  logic signed [39:0] az, w0, w1, w2;
  logic signed [39:0] w0n;
  logic signed [63:0] num;
  logic signed [18:0] ma;
  logic signed [24:0] mb;
  logic signed [43:0] prod;

  logic               neg;
  logic signed [63:0] nn;
  logic [DB-1:0]      dd;
  logic               div_start;
  logic               div_done;
  logic [DB-1:0]      quot;
  logic signed [64:0] qs;
  logic signed [DEPTH_BITS-1:0] zval;
  logic signed [63:0] zx;

  logic               zrd, zwr;
  logic [DEPTH_BITS-1:0] zrdata;
  logic               zready;
  logic               out_free;
  logic               push;
  logic               accept;
  logic               nearer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= tdtr_pkg::IMAGE_WIDTH_RST;
      image_height <= tdtr_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tdtr_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        tdtr_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // image limits clamped to the store
  assign wl = (32'(image_width) > 32'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(image_width);
  assign hl = (32'(image_height) > 32'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(image_height);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE) || !zready;
  assign out_free = !out_valid || !out_stall;

  // capture the word with edge vectors, store index and image check
  always_ff @(posedge clk) begin
    if (accept) begin
      item  <= in_word;
      e1x   <= 17'(in_word.v1_x) - 17'(in_word.v0_x);
      e1y   <= 17'(in_word.v1_y) - 17'(in_word.v0_y);
      e2x   <= 17'(in_word.v2_x) - 17'(in_word.v0_x);
      e2y   <= 17'(in_word.v2_y) - 17'(in_word.v0_y);
      dx    <= 18'(in_word.v0_x) - 18'($signed({1'b0, in_word.pixel_x, 4'b0000}));
      dy    <= 18'(in_word.v0_y) - 18'($signed({1'b0, in_word.pixel_y, 4'b0000}));
      idx   <= AW'(AW'(in_word.pixel_y) * AW'(wl)) + AW'(in_word.pixel_x);
      inimg <= (32'(in_word.pixel_x) < 32'(wl)) && (32'(in_word.pixel_y) < 32'(hl));
    end
  end

  // shared multiplier operand selection
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == ST_WMUL) begin
      case (k)
        3'd0: begin ma = 19'(e2x); mb = 25'(e1y); end
        3'd1: begin ma = 19'(e1x); mb = 25'(e2y); end
        3'd2: begin ma = 19'(dx);  mb = 25'(e2y); end
        3'd3: begin ma = 19'(e2x); mb = 25'(dy);  end
        3'd4: begin ma = 19'(e1x); mb = 25'(dy);  end
        3'd5: begin ma = 19'(dx);  mb = 25'(e1y); end
        default: ;
      endcase
    end else begin
      case (k)
        3'd0: begin ma = $signed({1'b0, w0[17:0]});  mb = 25'(item.v0_z); end
        3'd1: begin ma = $signed({1'b0, w0[35:18]}); mb = 25'(item.v0_z); end
        3'd2: begin ma = $signed({1'b0, w1[17:0]});  mb = 25'(item.v1_z); end
        3'd3: begin ma = $signed({1'b0, w1[35:18]}); mb = 25'(item.v1_z); end
        3'd4: begin ma = $signed({1'b0, w2[17:0]});  mb = 25'(item.v2_z); end
        3'd5: begin ma = $signed({1'b0, w2[35:18]}); mb = 25'(item.v2_z); end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // third weight from the area
  assign w0n = az - w1 - w2;

  // divider operands: floor((2*num + az) / (2*az))
  assign nn  = (num <<< 1) + 64'(az);
  assign dd  = DB'(64'(az) <<< 1);

  // signed quotient back from the magnitude
  assign qs = neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // weight and numerator accumulation
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        az  <= '0;
        w1  <= '0;
        w2  <= '0;
        num <= '0;
      end
      ST_WMUL: begin
        case (k)
          3'd1: az <= az + 40'(prod);
          3'd2: az <= az - 40'(prod);
          3'd3: w1 <= w1 + 40'(prod);
          3'd4: w1 <= w1 - 40'(prod);
          3'd5: w2 <= w2 + 40'(prod);
          3'd6: w2 <= w2 - 40'(prod);
          default: ;
        endcase
      end
      ST_NORM: begin
        // orient the triangle so the area is positive
        if (az < 0) begin
          az <= -az;
          w0 <= -w0n;
          w1 <= -w1;
          w2 <= -w2;
        end else begin
          w0 <= w0n;
        end
      end
      ST_NMUL: begin
        case (k)
          3'd1, 3'd3, 3'd5: num <= num + 64'(prod);
          3'd2, 3'd4, 3'd6: num <= num + (64'(prod) <<< 18);
          default: ;
        endcase
      end
      ST_DIVS: begin
        neg <= nn[63];
      end
      ST_DIVW: begin
        // saturate the quotient to the store width
        if (div_done) begin
          if (qs > ZMAX) begin
            zval <= DEPTH_BITS'(ZMAX);
          end else if (qs < ZMIN) begin
            zval <= DEPTH_BITS'(ZMIN);
          end else begin
            zval <= DEPTH_BITS'(qs);
          end
        end
      end
      ST_RD, ST_CMP, ST_REJ: ;
      default: ;
    endcase
  end

  assign div_start = (state == ST_DIVS);

  tdtr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (nn[63] ? DB'(-nn + $signed(dd) - 64'sd1) : DB'(nn)),
    .divisor  (dd),
    .done     (div_done),
    .quotient (quot)
  );

  // depth test
  assign nearer = zval < $signed(zrdata);
  assign zrd    = (state == ST_RD);
  assign push   = out_free && ((state == ST_CMP) || (state == ST_REJ));
  assign zwr    = push && (state == ST_CMP) && nearer;

  tdtr_zmem #(
    .DEPTH (DEPTH),
    .DB    (DEPTH_BITS),
    .AW    (AW)
  ) u_zmem (
    .clk   (clk),
    .rst   (rst),
    .rd    (zrd),
    .wr    (zwr),
    .addr  (idx),
    .wdata (zval),
    .rdata (zrdata),
    .ready (zready)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_WMUL;
      ST_WMUL: if (k == 3'd6) state_next = ST_NORM;
      ST_NORM: begin
        if (inimg && (az < 0 ? -az : az) >= 40'sd256 &&
            (az < 0 ? (w0n <= 0 && w1 <= 0 && w2 <= 0)
                    : (w0n >= 0 && w1 >= 0 && w2 >= 0))) begin
          state_next = ST_NMUL;
        end else begin
          state_next = ST_REJ;
        end
      end
      ST_NMUL: if (k == 3'd6) state_next = ST_DIVS;
      ST_DIVS: state_next = ST_DIVW;
      ST_DIVW: if (div_done) state_next = ST_RD;
      ST_RD:   state_next = ST_CMP;
      ST_CMP:  if (push) state_next = ST_IDLE;
      ST_REJ:  if (push) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state_next != state) begin
        k <= '0;
      end else if (state == ST_WMUL || state == ST_NMUL) begin
        k <= k + 1'b1;
      end
    end
  end

  // output register
  assign zx = 64'(zval);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_word.out_x <= item.pixel_x;
      out_word.out_y <= item.pixel_y;
      if (state == ST_CMP) begin
        out_word.write_enable <= nearer;
        out_word.out_color    <= nearer ? item.pixel_color : 32'd0;
        out_word.out_depth    <= zx[23:0];
      end else begin
        out_word.write_enable <= 1'b0;
        out_word.out_color    <= 32'd0;
        out_word.out_depth    <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // store writes only with the word that reports them
  a_write_with_push: assert property (@(posedge clk) disable iff (rst)
    zwr |-> push && out_free) else $error("depth write without output word");

  // no word taken while the store is being swept
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    !zready |-> in_stall) else $error("word accepted during clearing");

  // divider finishes only while it is awaited
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIVW) else $error("unexpected divider completion");

  // colour is zero on a word that does not write
  a_color_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.write_enable |-> out_word.out_color == 32'd0)
    else $error("colour on non-writing word");
`endif

endmodule

/* hdl/tdtr_div.sv */
// iterative restoring divider, one quotient bit per cycle
module tdtr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tdtr_pkg::DIV_BITS-1:0] dividend,
  input  logic [tdtr_pkg::DIV_BITS-1:0] divisor,
  output logic                          done,
  output logic [tdtr_pkg::DIV_BITS-1:0] quotient
);

  localparam int DB = tdtr_pkg::DIV_BITS;
  localparam int CB = $clog2(DB);

  logic [DB-1:0] rem;
  logic [DB-1:0] quo;
  logic [DB-1:0] dvs;
  logic [CB-1:0] cnt;
  logic          busy;
  logic [DB:0]   rem_sh;
  logic [DB:0]   diff;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem, quo[DB-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CB'(DB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[DB]) begin
        rem <= diff[DB-1:0];
        quo <= {quo[DB-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DB-1:0];
        quo <= {quo[DB-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

/* hdl/tdtr_zmem.sv */
// depth store memory with clearing pass after reset
module tdtr_zmem #(
  parameter int DEPTH = tdtr_pkg::MAX_WIDTH_DEF * tdtr_pkg::MAX_HEIGHT_DEF,
  parameter int DB    = tdtr_pkg::DEPTH_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd,
  input  logic          wr,
  input  logic [AW-1:0] addr,
  input  logic [DB-1:0] wdata,
  output logic [DB-1:0] rdata,
  output logic          ready
);

  localparam logic [DB-1:0] FAR = {1'b0, {(DB-1){1'b1}}};

  logic [DB-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          clr_busy;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // single port array
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= FAR;
    end else if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[addr];
    end
  end

  assign ready = !clr_busy;

endmodule
